@@ sv/adpt_pkg.sv @@
// Shared types, codes and constants of the pump relay timer.
package adpt_pkg;

    localparam int unsigned DUR_W    = 32;
    localparam int unsigned PCT_W    = 7;
    localparam int unsigned FLOW_W   = 13;
    localparam int unsigned MASK_W   = 4;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 13;
    localparam int unsigned MOIST_FIELDS = 4;

    // Dose dividend is volume in ml times 100000, at most 1500000.
    localparam int unsigned DVD_W = 21;

    localparam logic [DVD_W-1:0] DVD_5ML  = 21'd500000;
    localparam logic [DVD_W-1:0] DVD_10ML = 21'd1000000;
    localparam logic [DVD_W-1:0] DVD_15ML = 21'd1500000;

    localparam logic [DVD_W-1:0] DOSE_MIN_MS = 21'd1000;
    localparam logic [DVD_W-1:0] DOSE_MAX_MS = 21'd30000;

    localparam logic [PCT_W-1:0] BAND_LOW  = 7'd10;
    localparam logic [PCT_W-1:0] BAND_MID  = 7'd20;

    localparam logic [CFG_DAT_W-1:0] THRESH_MAX = 13'd100;
    localparam logic [CFG_DAT_W-1:0] FLOW_MIN   = 13'd5;
    localparam logic [CFG_DAT_W-1:0] FLOW_MAX   = 13'd5000;

    localparam logic [PCT_W-1:0]  THRESH_RST = 7'd30;
    localparam logic [FLOW_W-1:0] FLOW_RST   = 13'd100;

    typedef enum logic [1:0] {
        REQ_TICK = 2'd0,
        REQ_RUN  = 2'd1,
        REQ_STOP = 2'd2
    } t_req;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AUTO_ENABLE = 3'd0,
        CFG_THRESHOLD   = 3'd1,
        CFG_FLOW_RATE   = 3'd2,
        CFG_SENSOR_MASK = 3'd3,
        CFG_ACTIVE_HIGH = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic              auto_enable;
        logic [PCT_W-1:0]  auto_threshold;
        logic [FLOW_W-1:0] flow_rate;
        logic [MASK_W-1:0] sensor_mask;
        logic              active_high;
    } t_cfg;

endpackage

@@ sv/adpt_cfg.sv @@
// Configuration register bank with write saturation.
module adpt_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [adpt_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [adpt_pkg::CFG_DAT_W-1:0]   i_cfg_data,
    output adpt_pkg::t_cfg                   o_cfg
);
    import adpt_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.auto_enable    <= 1'b0;
            r_cfg.auto_threshold <= THRESH_RST;
            r_cfg.flow_rate      <= FLOW_RST;
            r_cfg.sensor_mask    <= '0;
            r_cfg.active_high    <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_AUTO_ENABLE: r_cfg.auto_enable <= i_cfg_data[0];
                CFG_THRESHOLD: begin
                    if (i_cfg_data > THRESH_MAX) begin
                        r_cfg.auto_threshold <= THRESH_MAX[PCT_W-1:0];
                    end else begin
                        r_cfg.auto_threshold <= i_cfg_data[PCT_W-1:0];
                    end
                end
                CFG_FLOW_RATE: begin
                    if (i_cfg_data < FLOW_MIN) begin
                        r_cfg.flow_rate <= FLOW_MIN[FLOW_W-1:0];
                    end else if (i_cfg_data > FLOW_MAX) begin
                        r_cfg.flow_rate <= FLOW_MAX[FLOW_W-1:0];
                    end else begin
                        r_cfg.flow_rate <= i_cfg_data[FLOW_W-1:0];
                    end
                end
                CFG_SENSOR_MASK: r_cfg.sensor_mask <= i_cfg_data[MASK_W-1:0];
                CFG_ACTIVE_HIGH: r_cfg.active_high <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ sv/adpt_div.sv @@
// Restoring divider that produces one quotient bit per cycle.
module adpt_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [adpt_pkg::DVD_W-1:0]    i_dividend,
    input  logic [adpt_pkg::FLOW_W-1:0]   i_divisor,
    output logic                          o_done,
    output logic [adpt_pkg::DVD_W-1:0]    o_quotient
);
    import adpt_pkg::*;

    localparam int unsigned CNT_W = $clog2(DVD_W);

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_count;
    logic [FLOW_W-1:0]   r_rem;
    logic [DVD_W-1:0]    r_quo;
    logic [FLOW_W-1:0]   r_divisor;

    logic [FLOW_W:0]     rem_shift;
    logic [FLOW_W:0]     diff;
    logic                fits;

    // The partial remainder stays below the divisor, so one more bit fits.
    assign rem_shift = {r_rem, r_quo[DVD_W-1]};
    assign diff      = rem_shift - {1'b0, r_divisor};
    assign fits      = rem_shift >= {1'b0, r_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy    <= 1'b1;
                r_count   <= '0;
                r_rem     <= '0;
                r_quo     <= i_dividend;
                r_divisor <= i_divisor;
            end else if (r_busy) begin
                r_rem <= fits ? diff[FLOW_W-1:0] : rem_shift[FLOW_W-1:0];
                r_quo <= {r_quo[DVD_W-2:0], fits};
                if (r_count == CNT_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_count <= r_count + 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

@@ sv/auto_dosing_pump_timer.sv @@
// Top level of the pump relay timer with automatic dosing.
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+-----------------------------------
//  in       | input     | i_in_valid / o_in_stall | req_type, duration_ms, moisture x4
//  out      | output    | o_out_valid / i_out_stall | pump_running, relay_level,
//           |           |                        | remaining_ms, auto_started
//  cfg      | input     | i_cfg_we               | i_cfg_index, i_cfg_data
//
// For ticks, runs and stops that start no dose, the result is registered at
// the edge that accepts the request. A tick that starts a dose runs the
// bit-serial divider; its result is registered once the divider is done,
// and the next request is taken after the block has returned to idle.
// Reset is synchronous and active low; it stops the pump and restores defaults.
// The input stalls while the divider works and while a result is held stalled.
module auto_dosing_pump_timer #(
    parameter int unsigned SENSOR_COUNT = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,

    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [1:0]                     i_req_type,
    input  logic [adpt_pkg::DUR_W-1:0]     i_duration_ms,
    input  logic [adpt_pkg::PCT_W-1:0]     i_moisture_pct_0,
    input  logic [adpt_pkg::PCT_W-1:0]     i_moisture_pct_1,
    input  logic [adpt_pkg::PCT_W-1:0]     i_moisture_pct_2,
    input  logic [adpt_pkg::PCT_W-1:0]     i_moisture_pct_3,

    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_pump_running,
    output logic                           o_relay_level,
    output logic [adpt_pkg::DUR_W-1:0]     o_remaining_ms,
    output logic                           o_auto_started,

    input  logic                           i_cfg_we,
    input  logic [adpt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [adpt_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    import adpt_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_DIVIDE
    } t_state;

    t_state             r_state;
    logic               r_running;
    logic [DUR_W-1:0]   r_time_left;

    logic               r_out_valid;
    logic               r_pump_running;
    logic               r_relay_level;
    logic [DUR_W-1:0]   r_remaining_ms;
    logic               r_auto_started;

    t_cfg               cfg;
    logic               div_done;
    logic [DVD_W-1:0]   div_quotient;
    logic [DVD_W-1:0]   dividend;
    logic [DVD_W-1:0]   dose_ms;

    logic               in_accept;
    logic               out_free;
    logic [PCT_W-1:0]   moisture [MOIST_FIELDS];
    logic               needs_water;
    logic [DUR_W-1:0]   tl_dec;
    logic               n_running;
    logic [DUR_W-1:0]   n_time_left;
    logic               start_dose;

    adpt_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // The output register can take a new result when it is empty or is
    // being drained at this edge.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == S_IDLE) && out_free);
    assign in_accept  = i_in_valid && !o_in_stall;

    assign moisture[0] = i_moisture_pct_0;
    assign moisture[1] = i_moisture_pct_1;
    assign moisture[2] = i_moisture_pct_2;
    assign moisture[3] = i_moisture_pct_3;

    // A sensor asks for water when it is enabled, exists in this build and
    // reads below the threshold.
    always_comb begin
        needs_water = 1'b0;
        for (int i = 0; i < MOIST_FIELDS; i++) begin
            if (i < SENSOR_COUNT && cfg.sensor_mask[i] &&
                moisture[i] < cfg.auto_threshold) begin
                needs_water = 1'b1;
            end
        end
    end

    assign tl_dec = (r_time_left != '0) ? r_time_left - 1'b1 : r_time_left;

    // Next pump state for the request that is offered. A tick first counts
    // down an active run; a dose is started only if the pump is then idle.
    always_comb begin
        n_running   = r_running;
        n_time_left = r_time_left;
        start_dose  = 1'b0;
        unique case (t_req'(i_req_type))
            REQ_TICK: begin
                if (r_running) begin
                    if (tl_dec == '0) begin
                        n_running   = 1'b0;
                        n_time_left = '0;
                    end else begin
                        n_time_left = tl_dec;
                    end
                end
                if (cfg.auto_enable && needs_water && !n_running) begin
                    start_dose = 1'b1;
                end
            end
            REQ_RUN: begin
                if (i_duration_ms == '0) begin
                    n_running   = 1'b0;
                    n_time_left = '0;
                end else begin
                    n_running   = 1'b1;
                    n_time_left = i_duration_ms;
                end
            end
            REQ_STOP: begin
                n_running   = 1'b0;
                n_time_left = '0;
            end
            default: ;
        endcase
    end

    // Dose volume by threshold band: 15 ml below 10, 10 ml below 20, else 5 ml.
    always_comb begin
        priority if (cfg.auto_threshold < BAND_LOW) begin
            dividend = DVD_15ML;
        end else if (cfg.auto_threshold < BAND_MID) begin
            dividend = DVD_10ML;
        end else begin
            dividend = DVD_5ML;
        end
    end

    adpt_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (in_accept && start_dose),
        .i_dividend (dividend),
        .i_divisor  (cfg.flow_rate),
        .o_done     (div_done),
        .o_quotient (div_quotient)
    );

    always_comb begin
        priority if (div_quotient < DOSE_MIN_MS) begin
            dose_ms = DOSE_MIN_MS;
        end else if (div_quotient > DOSE_MAX_MS) begin
            dose_ms = DOSE_MAX_MS;
        end else begin
            dose_ms = div_quotient;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_running   <= 1'b0;
            r_time_left <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_running   <= n_running;
                        r_time_left <= n_time_left;
                        if (start_dose) begin
                            // A request is only taken when the output
                            // register is empty or drains at this edge.
                            r_state     <= S_DIVIDE;
                            r_out_valid <= 1'b0;
                        end else begin
                            r_out_valid    <= 1'b1;
                            r_pump_running <= n_running;
                            r_relay_level  <= n_running ? cfg.active_high
                                                        : !cfg.active_high;
                            r_remaining_ms <= n_running ? n_time_left : '0;
                            r_auto_started <= 1'b0;
                        end
                    end else if (r_out_valid && !i_out_stall) begin
                        r_out_valid <= 1'b0;
                    end
                end
                S_DIVIDE: begin
                    // The output register was drained when this request was
                    // taken, so it is free when the quotient arrives.
                    if (div_done) begin
                        r_state        <= S_IDLE;
                        r_running      <= 1'b1;
                        r_time_left    <= DUR_W'(dose_ms);
                        r_out_valid    <= 1'b1;
                        r_pump_running <= 1'b1;
                        r_relay_level  <= cfg.active_high;
                        r_remaining_ms <= DUR_W'(dose_ms);
                        r_auto_started <= 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pump_running = r_pump_running;
    assign o_relay_level  = r_relay_level;
    assign o_remaining_ms = r_remaining_ms;
    assign o_auto_started = r_auto_started;

endmodule
